[rtl/pdrs_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the
// pump duty rotation selector. No dependencies.
`default_nettype none

package pdrs_pkg;

  localparam int MAX_PUMPS_DEF = 8;

  localparam logic [1:0] ROLE_WORKING = 2'd0;
  localparam logic [1:0] ROLE_STANDBY = 2'd1;
  localparam logic [1:0] ROLE_NONE    = 2'd2;

  localparam logic [7:0] STATUS_FAULT = 8'd2;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  localparam logic MODE_HOURS = 1'b0;
  localparam logic MODE_ROUND = 1'b1;

  // Register index, taken from paddr[2]
  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  localparam logic [3:0] PUMP_COUNT_RST = 4'd8;

  typedef struct packed {
    logic capture;     // latch a select request
    logic write;       // write one table entry
    logic reduce;      // one subtract step of the start-index reduction
    logic begin_scan;  // load scan pointer and clear pass counter
    logic from_zero;   // begin_scan starts at entry 0
    logic step;        // examine one entry and advance
    logic standby;     // pass looks for standby pumps
  } pdrs_cmd_t;

  typedef struct packed {
    logic n_zero;     // no pump in use
    logic red_ge;     // start index still at or above pump count
    logic scan_last;  // current entry is the last of the pass
    logic hit;        // current entry qualifies for the pass
    logic have;       // a pump has been picked
  } pdrs_sts_t;

endpackage

`default_nettype wire

[rtl/pdrs_ctrl.sv]
// Sequencer for the pump selector: accepts requests and steps the datapath
// through reduction, working pass and standby pass. Uses pdrs_pkg.
`default_nettype none

module pdrs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               operation,
  input  wire pdrs_pkg::pdrs_sts_t sts,
  output pdrs_pkg::pdrs_cmd_t     cmd,
  output logic                    busy,
  output logic                    out_valid
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REDUCE = 3'd1;
  localparam logic [2:0] ST_SCAN_W = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_SCAN_S = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (operation == pdrs_pkg::OP_SELECT) begin
            cmd.capture = 1'b1;
            state_nxt   = ST_REDUCE;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      ST_REDUCE: begin
        if (sts.n_zero) begin
          state_nxt = ST_DONE;
        end else if (sts.red_ge) begin
          cmd.reduce = 1'b1;
        end else begin
          cmd.begin_scan = 1'b1;
          state_nxt      = ST_SCAN_W;
        end
      end
      ST_SCAN_W: begin
        cmd.step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.have) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.begin_scan = 1'b1;
          cmd.from_zero  = 1'b1;
          state_nxt      = ST_SCAN_S;
        end
      end
      ST_SCAN_S: begin
        cmd.step    = 1'b1;
        cmd.standby = 1'b1;
        if (sts.hit || sts.scan_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);

endmodule

`default_nettype wire

[rtl/pdrs_dp.sv]
// Datapath for the pump selector: pump tables, start-index reduction, scan
// pointer and the running pick. Uses pdrs_pkg.
`default_nettype none

module pdrs_dp #(
  parameter int MAX_PUMPS = pdrs_pkg::MAX_PUMPS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire pdrs_pkg::pdrs_cmd_t cmd,
  output pdrs_pkg::pdrs_sts_t      sts,
  input  wire logic                cfg_mode,
  input  wire logic [3:0]          cfg_count,
  input  wire logic [2:0]          in_pump_index,
  input  wire logic [1:0]          in_pump_role,
  input  wire logic [7:0]          in_pump_status,
  input  wire logic [31:0]         in_run_time,
  input  wire logic [2:0]          in_last_active,
  input  wire logic                in_last_active_valid,
  output logic                     out_found,
  output logic [2:0]               out_selected_pump
);

  localparam int IW = (MAX_PUMPS > 1) ? $clog2(MAX_PUMPS) : 1;
  localparam int NW = $clog2(MAX_PUMPS + 1);
  localparam int RW = (NW > 4) ? NW : 4;

  logic [1:0]    role_r  [MAX_PUMPS];
  logic [1:0]    role_nxt[MAX_PUMPS];
  logic          fault_r  [MAX_PUMPS];
  logic          fault_nxt[MAX_PUMPS];
  logic [31:0]   hours_r  [MAX_PUMPS];
  logic [31:0]   hours_nxt[MAX_PUMPS];

  logic [NW-1:0] n_r, n_nxt;
  logic [RW-1:0] red_r, red_nxt;
  logic [IW-1:0] ptr_r, ptr_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          have_r, have_nxt;
  logic [IW-1:0] pick_r, pick_nxt;
  logic [31:0]   least_r, least_nxt;

  logic [NW-1:0] n_sat;
  logic [NW-1:0] ptr_inc;
  logic [1:0]    want_role;
  logic          elig;
  logic          take;
  logic          wr_ok;
  logic [IW-1:0] wr_addr;

  // Saturate pump count to the table depth
  assign n_sat     = (int'(cfg_count) > MAX_PUMPS) ? NW'(MAX_PUMPS) : NW'(cfg_count);
  assign ptr_inc   = NW'(ptr_r) + NW'(1);
  assign want_role = cmd.standby ? pdrs_pkg::ROLE_STANDBY : pdrs_pkg::ROLE_WORKING;
  assign elig      = (role_r[ptr_r] == want_role) && !fault_r[ptr_r];
  assign wr_ok     = int'(in_pump_index) < MAX_PUMPS;
  assign wr_addr   = IW'(in_pump_index);

  // Hours pass keeps the strictly smaller run time; other passes keep the first
  always_comb begin
    if (!cmd.standby && (cfg_mode == pdrs_pkg::MODE_HOURS)) begin
      take = elig && (!have_r || (hours_r[ptr_r] < least_r));
    end else begin
      take = elig && !have_r;
    end
  end

  always_comb begin
    role_nxt  = role_r;
    fault_nxt = fault_r;
    hours_nxt = hours_r;
    n_nxt     = n_r;
    red_nxt   = red_r;
    ptr_nxt   = ptr_r;
    cnt_nxt   = cnt_r;
    have_nxt  = have_r;
    pick_nxt  = pick_r;
    least_nxt = least_r;
    if (cmd.write && wr_ok) begin
      role_nxt[wr_addr]  = in_pump_role;
      fault_nxt[wr_addr] = (in_pump_status == pdrs_pkg::STATUS_FAULT);
      hours_nxt[wr_addr] = in_run_time;
    end
    if (cmd.capture) begin
      n_nxt     = n_sat;
      red_nxt   = ((cfg_mode == pdrs_pkg::MODE_ROUND) && in_last_active_valid)
                  ? RW'(in_last_active) + RW'(1) : '0;
      have_nxt  = 1'b0;
      pick_nxt  = '0;
      least_nxt = '0;
    end
    if (cmd.reduce) begin
      red_nxt = red_r - RW'(n_r);
    end
    if (cmd.begin_scan) begin
      ptr_nxt = cmd.from_zero ? '0 : IW'(red_r);
      cnt_nxt = '0;
    end
    if (cmd.step) begin
      if (take) begin
        have_nxt  = 1'b1;
        pick_nxt  = ptr_r;
        least_nxt = hours_r[ptr_r];
      end
      ptr_nxt = (ptr_inc == n_r) ? '0 : IW'(ptr_inc);
      cnt_nxt = NW'(cnt_r + NW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PUMPS; i++) begin
        role_r[i]  <= pdrs_pkg::ROLE_NONE;
        fault_r[i] <= 1'b0;
        hours_r[i] <= '0;
      end
      have_r <= 1'b0;
      pick_r <= '0;
    end else begin
      role_r  <= role_nxt;
      fault_r <= fault_nxt;
      hours_r <= hours_nxt;
      have_r  <= have_nxt;
      pick_r  <= pick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    red_r   <= red_nxt;
    ptr_r   <= ptr_nxt;
    cnt_r   <= cnt_nxt;
    least_r <= least_nxt;
  end

  always_comb begin
    sts           = '0;
    sts.n_zero    = (n_r == '0);
    sts.red_ge    = (red_r >= RW'(n_r));
    sts.scan_last = (NW'(cnt_r + NW'(1)) == n_r);
    sts.hit       = elig;
    sts.have      = have_r;
  end

  assign out_found         = have_r;
  assign out_selected_pump = 3'(pick_r);

endmodule

`default_nettype wire

[rtl/pump_duty_rotation_select_core.sv]
// Top level of the pump duty rotation selector: configuration registers on
// an APB-style port, controller and datapath. Uses pdrs_pkg, pdrs_ctrl, pdrs_dp.
// Write requests leave busy low, so a new request may follow in the next
// cycle. A select request holds busy through the start-index reduction (round
// robin only), the working pass over every pump in use and, only when no
// working pump is found, the standby pass, which ends at the first standby pump
// it can pick; the scan reads one table entry per cycle. With a pump count of
// zero the select skips the reduction and both passes. The result strobe comes
// in the last busy cycle and cannot be stalled. Synchronous reset marks every
// pump not taking part, healthy, zero run time; mode hours, pump count 8.
`default_nettype none

module pump_duty_rotation_select_core #(
  parameter int MAX_PUMPS = pdrs_pkg::MAX_PUMPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // request channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_operation,
  input  wire logic [2:0]  in_pump_index,
  input  wire logic [1:0]  in_pump_role,
  input  wire logic [7:0]  in_pump_status,
  input  wire logic [31:0] in_run_time,
  input  wire logic [2:0]  in_last_active,
  input  wire logic        in_last_active_valid,
  // result channel
  output logic             out_valid,
  output logic             out_found,
  output logic [2:0]       out_selected_pump
);

  logic       mode_r, mode_nxt;
  logic [3:0] count_r, count_nxt;
  logic       cfg_wr;
  logic       ctrl_start;

  pdrs_pkg::pdrs_cmd_t cmd;
  pdrs_pkg::pdrs_sts_t sts;

  // Registers sit at 4-byte steps; the register index is paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    mode_nxt  = mode_r;
    count_nxt = count_r;
    if (cfg_wr) begin
      unique case (paddr[2])
        pdrs_pkg::REG_MODE:  mode_nxt  = pwdata[0];
        pdrs_pkg::REG_COUNT: count_nxt = pwdata[3:0];
        default:             mode_nxt  = mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= pdrs_pkg::MODE_HOURS;
      count_r <= pdrs_pkg::PUMP_COUNT_RST;
    end else begin
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (paddr[2])
      pdrs_pkg::REG_MODE:  prdata = {31'd0, mode_r};
      pdrs_pkg::REG_COUNT: prdata = {28'd0, count_r};
      default:             prdata = '0;
    endcase
  end

  // Drop start while a select is in flight
  assign ctrl_start = start && !busy;

  pdrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (ctrl_start),
    .operation (in_operation),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  pdrs_dp #(
    .MAX_PUMPS (MAX_PUMPS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_mode             (mode_r),
    .cfg_count            (count_r),
    .in_pump_index        (in_pump_index),
    .in_pump_role         (in_pump_role),
    .in_pump_status       (in_pump_status),
    .in_run_time          (in_run_time),
    .in_last_active       (in_last_active),
    .in_last_active_valid (in_last_active_valid),
    .out_found            (out_found),
    .out_selected_pump    (out_selected_pump)
  );

  // Result strobe lasts one cycle only
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // A select request must occupy the block
  a_select_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_operation == pdrs_pkg::OP_SELECT)) |=> busy)
    else $error("select request did not raise busy");

  // A write request completes in its accept cycle
  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_operation == pdrs_pkg::OP_WRITE)) |=> !busy)
    else $error("write request left the block busy");

  // An empty result reports pump zero
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_selected_pump == 3'd0))
    else $error("empty result carries a pump index");

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Self-checking bench for pump_duty_rotation_select_core: directed and random
// write/select requests over both rotation modes and a spread of pump counts.
// Depends on pdrs_pkg and the core RTL; results are checked against a local pump table.

module tb_top;

  localparam int CLK_HALF    = 10;
  localparam int STALL_LIMIT = 4000;  // cycles with no handshake of any kind
  localparam int SETTLE      = 8;     // lets a last write request land; leave margin
  localparam int BATCH_LEN   = 65;

  // Role code 3 has no name in the package; the table treats it as idle.
  localparam logic [1:0] ROLE_SPARE = 2'd3;

  typedef struct packed {
    logic        op;
    logic [2:0]  idx;
    logic [1:0]  role;
    logic [7:0]  status;
    logic [31:0] run_min;
    logic [2:0]  last;
    logic        last_ok;
  } pump_req_t;

  typedef struct packed {
    logic       found;
    logic [2:0] pump;
  } pump_pick_t;

  logic        clk     = 1'b0;
  logic        rst_n   = 1'b0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start   = 1'b0;
  logic        busy;
  pump_req_t   drv     = '0;
  logic        out_valid;
  logic        out_found;
  logic [2:0]  out_selected_pump;

  // Local copy of the pump table and the two registers
  logic [1:0]  role_tab  [pdrs_pkg::MAX_PUMPS_DEF];
  logic        fault_tab [pdrs_pkg::MAX_PUMPS_DEF];
  logic [31:0] hours_tab [pdrs_pkg::MAX_PUMPS_DEF];
  logic        mode_reg;
  logic [3:0]  count_reg;

  pump_req_t   pending_reqs [$];
  pump_pick_t  expected_picks [$];

  int   pushed_n      = 0;
  int   taken_n       = 0;
  int   picks_checked = 0;
  int   cfg_writes    = 0;
  int   fail_n        = 0;
  int   stall_n       = 0;
  int   idle_pct      = 0;
  logic req_taken     = 1'b0;

  int         idle_plan  [3]  = '{13, 86, 0};
  logic [3:0] count_plan [12] = '{4'd8, 4'd1, 4'd5, 4'd0, 4'd3, 4'd15,
                                  4'd8, 4'd2, 4'd9, 4'd6, 4'd8, 4'd4};

  pump_duty_rotation_select_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .start               (start),
    .busy                (busy),
    .in_operation        (drv.op),
    .in_pump_index       (drv.idx),
    .in_pump_role        (drv.role),
    .in_pump_status      (drv.status),
    .in_run_time         (drv.run_min),
    .in_last_active      (drv.last),
    .in_last_active_valid(drv.last_ok),
    .out_valid           (out_valid),
    .out_found           (out_found),
    .out_selected_pump   (out_selected_pump)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // A pump may be picked for a pass if it carries the wanted role and no fault.
  function automatic logic pump_ready(input int i, input logic [1:0] role);
    return role_tab[i] == role && !fault_tab[i];
  endfunction

  // Work out which pump a select request should start with the table as it
  // stands now: working pumps first (least hours or round robin), then standby.
  function automatic pump_pick_t choose_pump(input logic [2:0] last, input logic last_ok);
    pump_pick_t  pick;
    logic        have;
    logic [31:0] least;
    int          n;
    int          i;
    pick  = '0;
    have  = 1'b0;
    least = '0;
    // counts above the table size saturate; zero leaves nothing to choose
    n = (int'(count_reg) > pdrs_pkg::MAX_PUMPS_DEF) ? pdrs_pkg::MAX_PUMPS_DEF
                                                    : int'(count_reg);
    if (n == 0) return pick;
    if (mode_reg == pdrs_pkg::MODE_HOURS) begin
      for (i = 0; i < n; i++) begin
        if (pump_ready(i, pdrs_pkg::ROLE_WORKING) && (!have || hours_tab[i] < least)) begin
          least     = hours_tab[i];
          pick.pump = 3'(i);
          have      = 1'b1;
        end
      end
    end else begin
      // scan on from the pump after the last active one, wrapping at n;
      // with no last active pump start from pump 0
      for (int k = 1; k <= n; k++) begin
        i = last_ok ? (int'(last) + k) % n : k - 1;
        if (!have && pump_ready(i, pdrs_pkg::ROLE_WORKING)) begin
          pick.pump = 3'(i);
          have      = 1'b1;
        end
      end
    end
    for (i = 0; i < n; i++) begin
      if (!have && pump_ready(i, pdrs_pkg::ROLE_STANDBY)) begin
        pick.pump = 3'(i);
        have      = 1'b1;
      end
    end
    pick.found = have;
    return pick;
  endfunction

  function automatic void report_mismatch(input string what, input int want, input int got);
    fail_n++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endfunction

  // Request issue: hold start until the request is taken, then either move
  // straight on to the next one or stay idle, as the current idle percentage says.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && !req_taken)) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
        drv   <= pending_reqs.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Sample everything at the rising edge: results first, so the queue front is
  // always the oldest select, then the request taken at this edge, then any
  // register write. The watchdog counts edges on which nothing moved.
  always @(posedge clk) begin : monitor
    pump_pick_t want;
    logic       moved;
    moved     = 1'b0;
    req_taken = rst_n && start && !busy;

    if (rst_n && out_valid) begin
      moved = 1'b1;
      if (expected_picks.size() == 0) begin
        fail_n++;
        $display("%0t: result with none pending, expected nothing, got found %0b pump %0d",
                 $time, out_found, out_selected_pump);
      end else begin
        want = expected_picks.pop_front();
        picks_checked++;
        if (out_found !== want.found)
          report_mismatch("found", want.found, out_found);
        if (out_selected_pump !== want.pump)
          report_mismatch("selected_pump", want.pump, out_selected_pump);
      end
    end

    if (req_taken) begin
      moved = 1'b1;
      taken_n++;
      if (drv.op == pdrs_pkg::OP_WRITE) begin
        // every 3-bit index is inside the table, so the write always lands
        role_tab[drv.idx]  = drv.role;
        fault_tab[drv.idx] = (drv.status == pdrs_pkg::STATUS_FAULT);
        hours_tab[drv.idx] = drv.run_min;
      end else begin
        expected_picks.insert(expected_picks.size(), choose_pump(drv.last, drv.last_ok));
      end
    end

    if (rst_n && psel && penable && pwrite && pready) begin
      moved = 1'b1;
      cfg_writes++;
      if (paddr[2] == pdrs_pkg::REG_MODE) mode_reg = pwdata[0];
      else count_reg = pwdata[3:0];
    end

    stall_n = moved ? 0 : stall_n + 1;
    if (stall_n >= STALL_LIMIT) begin
      $display("%0t: watchdog expired, %0d results still outstanding",
               $time, expected_picks.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic void submit(input pump_req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
    pushed_n++;
  endfunction

  function automatic void queue_write(input logic [2:0] idx, input logic [1:0] role,
                                      input logic [7:0] status, input logic [31:0] run_min);
    pump_req_t r;
    r         = '0;
    r.op      = pdrs_pkg::OP_WRITE;
    r.idx     = idx;
    r.role    = role;
    r.status  = status;
    r.run_min = run_min;
    submit(r);
  endfunction

  function automatic void queue_select(input logic [2:0] last, input logic last_ok);
    pump_req_t r;
    r         = '0;
    r.op      = pdrs_pkg::OP_SELECT;
    r.last    = last;
    r.last_ok = last_ok;
    submit(r);
  endfunction

  // Mostly working and standby pumps with a fair share of faults; run times
  // lean towards tiny values so that ties between pumps turn up often.
  function automatic pump_req_t random_request();
    pump_req_t r;
    r.op  = ($urandom_range(99) < 40) ? pdrs_pkg::OP_SELECT : pdrs_pkg::OP_WRITE;
    r.idx = 3'($urandom_range(7));
    case ($urandom_range(9))
      0, 1, 2, 3, 4: r.role = pdrs_pkg::ROLE_WORKING;
      5, 6, 7:       r.role = pdrs_pkg::ROLE_STANDBY;
      8:             r.role = pdrs_pkg::ROLE_NONE;
      default:       r.role = ROLE_SPARE;
    endcase
    r.status = ($urandom_range(4) == 0) ? pdrs_pkg::STATUS_FAULT : 8'($urandom_range(255));
    case ($urandom_range(7))
      0:       r.run_min = '0;
      1:       r.run_min = '1;
      2, 3:    r.run_min = 32'($urandom_range(3));
      default: r.run_min = $urandom();
    endcase
    r.last    = 3'($urandom_range(7));
    r.last_ok = 1'($urandom_range(1));
    return r;
  endfunction

  // Wait until every request is taken and every result is in, then let the
  // core finish any last table write before touching a register.
  task automatic wait_idle();
    while (taken_n != pushed_n || expected_picks.size() != 0 || busy) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_register(input logic reg_sel, input logic [31:0] value);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin : stimulus
    for (int i = 0; i < pdrs_pkg::MAX_PUMPS_DEF; i++) begin
      role_tab[i]  = pdrs_pkg::ROLE_NONE;
      fault_tab[i] = 1'b0;
      hours_tab[i] = '0;
    end
    mode_reg  = pdrs_pkg::MODE_HOURS;
    count_reg = pdrs_pkg::PUMP_COUNT_RST;
    idle_pct  = idle_plan[0];

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Hours mode straight out of reset: empty table, all-ones run time,
    // a tie on hours, a faulty working pump, role code 3, standby fallback.
    queue_select(3'd0, 1'b0);
    queue_write(3'd0, pdrs_pkg::ROLE_WORKING, 8'd0, 32'hFFFF_FFFF);
    queue_select(3'd7, 1'b1);
    queue_write(3'd7, pdrs_pkg::ROLE_WORKING, 8'd0, 32'd5);
    queue_write(3'd3, pdrs_pkg::ROLE_WORKING, 8'd0, 32'd5);
    queue_select(3'd0, 1'b0);
    queue_write(3'd3, pdrs_pkg::ROLE_WORKING, pdrs_pkg::STATUS_FAULT, 32'd5);
    queue_write(3'd7, pdrs_pkg::ROLE_WORKING, 8'hFF, 32'd0);
    queue_select(3'd0, 1'b0);
    queue_write(3'd1, ROLE_SPARE, 8'd0, 32'd0);
    queue_write(3'd2, pdrs_pkg::ROLE_STANDBY, 8'd1, 32'd0);
    queue_write(3'd0, pdrs_pkg::ROLE_NONE, 8'd0, 32'd0);
    queue_write(3'd7, pdrs_pkg::ROLE_STANDBY, pdrs_pkg::STATUS_FAULT, 32'hFFFF_FFFF);
    queue_select(3'd0, 1'b0);

    // Standby pump now sits beyond the pumps in use
    write_register(pdrs_pkg::REG_COUNT, 32'd2);
    queue_select(3'd0, 1'b0);

    // Round robin: wrap past the last pump, no last active pump,
    // last active beyond the count, no pumps at all, count saturating.
    write_register(pdrs_pkg::REG_MODE, {31'd0, pdrs_pkg::MODE_ROUND});
    write_register(pdrs_pkg::REG_COUNT, 32'd8);
    queue_write(3'd4, pdrs_pkg::ROLE_WORKING, 8'd3, 32'd9);
    queue_write(3'd6, pdrs_pkg::ROLE_WORKING, 8'd0, 32'd1);
    queue_select(3'd4, 1'b1);
    queue_select(3'd6, 1'b1);
    queue_select(3'd5, 1'b0);
    write_register(pdrs_pkg::REG_COUNT, 32'd5);
    queue_select(3'd7, 1'b1);
    write_register(pdrs_pkg::REG_COUNT, 32'd0);
    queue_select(3'd2, 1'b1);
    write_register(pdrs_pkg::REG_COUNT, 32'd15);
    queue_select(3'd2, 1'b1);

    // Random batches: each sender rate over four register settings
    for (int ph = 0; ph < 3; ph++) begin
      for (int b = 0; b < 4; b++) begin
        write_register(pdrs_pkg::REG_MODE,
                       {31'd0, ((ph + b) % 2 == 1) ? pdrs_pkg::MODE_ROUND
                                                   : pdrs_pkg::MODE_HOURS});
        write_register(pdrs_pkg::REG_COUNT, {28'd0, count_plan[ph * 4 + b]});
        idle_pct = idle_plan[ph];
        repeat (BATCH_LEN) submit(random_request());
      end
    end
    wait_idle();

    $display("Run covered %0d requests, %0d select results checked, %0d register writes,",
             taken_n, picks_checked, cfg_writes);
    $display("both rotation modes, pump counts from 0 up to 15, sender idle 13/86/0 pct.");
    if (fail_n == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
